// File: sv/pqs_pkg.sv
`timescale 1ns / 1ps

package pqs_pkg;

   localparam int MaxQueries = 64;
   localparam int TimeBits   = 32;
   localparam int IdBits     = 12;
   localparam int PeriodBits = 12;

   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_TAKE     = 1'b1;

   // one scheduled query as held by a cell
   typedef struct packed {
      logic                  valid;
      logic [TimeBits-1:0]   due;
      logic [IdBits-1:0]     id;
      logic [PeriodBits-1:0] period;
   } entry_type;

   // what the whole row of cells does in a cycle
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_REINSERT
   } state_type;

endpackage

// File: sv/periodic_query_scheduler.sv
`timescale 1ns / 1ps

// Periodic query scheduler: a sorted row of MaxQueries cells keeps the
// registered queries ordered by due time, then query number, then period,
// so the head cell always holds the next query to return. A register item
// gives no result unless the row is full, in which case it is dropped with
// full_res set. A take-next item pops the head into the result register
// and shifts the row left, then in ST_REINSERT inserts the head back with
// its due time advanced by its period (saturating with time_overflow when
// it leaves TimeBits); new items stall until it is back. Taking from an
// empty row returns empty_res with all other fields zero. The store starts
// empty after reset.
module periodic_query_scheduler (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [pqs_pkg::IdBits-1:0]      req_query_id,
   input  logic [pqs_pkg::PeriodBits-1:0]  req_period,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pqs_pkg::IdBits-1:0]      rsp_due_id,
   output logic [pqs_pkg::TimeBits-1:0]    rsp_due_time,
   output logic                            rsp_empty_res,
   output logic                            rsp_full_res,
   output logic                            rsp_time_overflow
);
   import pqs_pkg::*;

   state_type state_ff, state_in;

   // row of cells
   entry_type   cell_entry  [MaxQueries];
   logic        cell_before [MaxQueries];
   entry_type   new_entry;
   cell_op_type op;

   // head popped by a take, waiting to go back in
   entry_type pend_ff, pend_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IdBits-1:0]     rsp_id_ff, rsp_id_in;
   logic [TimeBits-1:0]   rsp_time_ff, rsp_time_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  accept;
   logic                  row_full, row_empty;
   logic [TimeBits:0]     next_sum;
   logic                  next_ovf;

   // row is sorted, so occupancy shows at its ends
   assign row_full  = cell_entry[MaxQueries-1].valid;
   assign row_empty = !cell_entry[0].valid;

   // a new item needs the scheduler idle and the result slot free or leaving this cycle
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // advanced due time of the head, saturated on carry out
   assign next_sum = {1'b0, cell_entry[0].due} +
                     {{(TimeBits + 1 - PeriodBits){1'b0}}, cell_entry[0].period};
   assign next_ovf = next_sum[TimeBits];

   // item to insert: the requested query, or the popped head on reinsert
   always_comb begin
      if (state_ff == ST_REINSERT) begin
         new_entry = pend_ff;
      end else begin
         new_entry.valid  = 1'b1;
         new_entry.due    = {{(TimeBits - PeriodBits){1'b0}}, req_period};
         new_entry.id     = req_query_id;
         new_entry.period = req_period;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_TAKE && !row_empty) begin
               state_in = ST_REINSERT;
            end
         end
         ST_REINSERT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // row operations
   always_comb begin
      op = '{insert: 1'b0, shift: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            op.insert = accept && req_command == CMD_REGISTER && !row_full;
            op.shift  = accept && req_command == CMD_TAKE && !row_empty;
         end
         ST_REINSERT: begin
            op.insert = 1'b1;
         end
         default: begin
            op = '{insert: 1'b0, shift: 1'b0};
         end
      endcase
   end

   // pending reinsert captured from the head at the pop
   always_comb begin
      pend_in = pend_ff;
      if (op.shift) begin
         pend_in.valid  = 1'b1;
         pend_in.due    = next_ovf ? {TimeBits{1'b1}} : next_sum[TimeBits-1:0];
         pend_in.id     = cell_entry[0].id;
         pend_in.period = cell_entry[0].period;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (accept) begin
         rsp_id_in    = '0;
         rsp_time_in  = '0;
         rsp_empty_in = 1'b0;
         rsp_full_in  = 1'b0;
         rsp_ovf_in   = 1'b0;
         if (req_command == CMD_REGISTER) begin
            // dropped register gives a full item, a stored one gives none
            rsp_valid_in = row_full;
            rsp_full_in  = 1'b1;
         end else if (row_empty) begin
            rsp_valid_in = 1'b1;
            rsp_empty_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = cell_entry[0].id;
            rsp_time_in  = cell_entry[0].due;
            rsp_ovf_in   = next_ovf;
         end
      end
   end

   // cells: each sees its neighbors and the left one's placement decision
   for (genvar i = 0; i < MaxQueries; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_b;

      if (i == 0) begin : g_first
         assign left_e = new_entry;
         assign left_b = 1'b0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_b = cell_before[i-1];
      end

      if (i == MaxQueries - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end

      pqs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_before (left_b),
         .entry       (cell_entry[i]),
         .new_before  (cell_before[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_due_id        = rsp_id_ff;
   assign rsp_due_time      = rsp_time_ff;
   assign rsp_empty_res     = rsp_empty_ff;
   assign rsp_full_res      = rsp_full_ff;
   assign rsp_time_overflow = rsp_ovf_ff;

endmodule

// File: sv/pqs_cell.sv
`timescale 1ns / 1ps

module pqs_cell (
   input  logic               clock,
   input  logic               reset,
   input  pqs_pkg::cell_op_type op,
   input  pqs_pkg::entry_type new_entry,
   input  pqs_pkg::entry_type left_entry,
   input  pqs_pkg::entry_type right_entry,
   input  logic               left_before,
   output pqs_pkg::entry_type entry,
   output logic               new_before
);
   import pqs_pkg::*;

   logic                  valid_ff, valid_in;
   logic [TimeBits-1:0]   due_ff, due_in;
   logic [IdBits-1:0]     id_ff, id_in;
   logic [PeriodBits-1:0] period_ff, period_in;
   entry_type             next_entry;

   assign entry = '{valid: valid_ff, due: due_ff, id: id_ff, period: period_ff};

   // empty cells sort after everything
   assign new_before = !valid_ff ||
      ({new_entry.due, new_entry.id, new_entry.period} < {due_ff, id_ff, period_ff});

   always_comb begin
      next_entry = entry;
      if (op.shift) begin
         next_entry = right_entry;
      end else if (op.insert && new_before) begin
         next_entry = left_before ? left_entry : new_entry;
      end
      valid_in  = next_entry.valid;
      due_in    = next_entry.due;
      id_in     = next_entry.id;
      period_in = next_entry.period;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      due_ff    <= due_in;
      id_ff     <= id_in;
      period_ff <= period_in;
   end

endmodule
